[rtl/rss_pkg.sv]
// rss_pkg: widths, codes and state encoding shared by the safety supervisor
// depends on nothing; imported by the interfaces, rss_mul and robot_safety_supervisor

package rss_pkg;

    // field widths
    localparam int OP_W       = 3;
    localparam int TS_W       = 32;
    localparam int GRAV_W     = 16;
    localparam int MIDX_W     = 4;
    localparam int TEMP_W     = 12;
    localparam int CODE_W     = 8;
    localparam int TAN_W      = 16;
    localparam int TOUT_W     = 16;
    localparam int KIND_W     = 3;
    localparam int VAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // motor table
    localparam int MOTOR_COUNT  = 16;
    localparam int MOTOR_AW     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SCAN_W       = MOTOR_AW + 1;
    localparam int MOTOR_WORD_W = CODE_W + TEMP_W;

    // shared multiplier
    localparam int MUL_W  = GRAV_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 32;

    // squared gravity norm must exceed this before tilt is judged
    localparam logic [ACC_W-1:0] TILT_MIN_SQ = ACC_W'(655);
    localparam logic [TS_W-1:0]  ELAPSED_MAX = TS_W'(32767);

    // reset values
    localparam logic [TAN_W-1:0]         PITCH_TAN_RST = TAN_W'(256);
    localparam logic [TAN_W-1:0]         ROLL_TAN_RST  = TAN_W'(148);
    localparam logic signed [TEMP_W-1:0] TEMP_LIM_RST  = TEMP_W'(800);
    localparam logic [TOUT_W-1:0]        CMD_TOUT_RST  = TOUT_W'(200);
    localparam logic [TOUT_W-1:0]        IMU_TOUT_RST  = TOUT_W'(200);
    localparam logic signed [GRAV_W-1:0] GRAV_Z_RST    = GRAV_W'(2511);

    typedef enum logic [OP_W-1:0] {
        OP_GRAVITY = 3'd0,
        OP_IMU     = 3'd1,
        OP_MOTOR   = 3'd2,
        OP_COMMAND = 3'd3,
        OP_CHECK   = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        K_NONE    = 3'd0,
        K_PITCH   = 3'd1,
        K_ROLL    = 3'd2,
        K_TEMP    = 3'd3,
        K_MFAULT  = 3'd4,
        K_CMD_TO  = 3'd5,
        K_IMU_TO  = 3'd6
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_TAN = 3'd0,
        CFG_ROLL_TAN  = 3'd1,
        CFG_TEMP_LIM  = 3'd2,
        CFG_CMD_TOUT  = 3'd3,
        CFG_IMU_TOUT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SCAN = 6'b000100,
        S_CMD  = 6'b001000,
        S_IMU  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

[rtl/rss_if.sv]
// rss_if: valid/ready channels of the safety supervisor (event in, result out, config)
// depends on rss_pkg for field widths

interface rss_in_if import rss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [TS_W-1:0]            timestamp_ms;
    logic signed [GRAV_W-1:0]   gravity_x;
    logic signed [GRAV_W-1:0]   gravity_y;
    logic signed [GRAV_W-1:0]   gravity_z;
    logic [MIDX_W-1:0]          motor_index;
    logic signed [TEMP_W-1:0]   motor_temperature;
    logic [CODE_W-1:0]          motor_fault_code;

    modport source (
        output valid, operation, timestamp_ms, gravity_x, gravity_y, gravity_z,
               motor_index, motor_temperature, motor_fault_code,
        input  ready
    );
    modport sink (
        input  valid, operation, timestamp_ms, gravity_x, gravity_y, gravity_z,
               motor_index, motor_temperature, motor_fault_code,
        output ready
    );
endinterface

interface rss_out_if import rss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     safe;
    logic [KIND_W-1:0]        fault_kind;
    logic [MIDX_W-1:0]        fault_motor;
    logic signed [VAL_W-1:0]  fault_value;
    logic                     new_fault;

    modport source (
        output valid, safe, fault_kind, fault_motor, fault_value, new_fault,
        input  ready
    );
    modport sink (
        input  valid, safe, fault_kind, fault_motor, fault_value, new_fault,
        output ready
    );
endinterface

interface rss_cfg_if import rss_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rss_ram.sv]
// rss_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rss_mul.sv]
// rss_mul: shared signed multiplier with registered product
// depends on rss_pkg for operand and product widths

module rss_mul
    import rss_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[rtl/robot_safety_supervisor.sv]
// Robot safety supervisor. Events (gravity sample, IMU heartbeat, motor state, command
// heartbeat) are absorbed in the cycle they are accepted and give no word. A check request
// gives one word naming the first fault in the order pitch, roll, motor over-temperature,
// motor fault code, command timeout, IMU timeout; new_fault marks a fault whose kind or
// motor differs from the previous check. A check keeps the block busy from acceptance to
// the result word: six steps through one shared 17x17 multiplier for the gravity norm
// and both tilt products, one motor ram read per motor, then one shared subtractor for
// both timeouts. The next event is taken once the result is in the output register;
// if a previous result is still not taken, the check waits for it. Config writes are
// always taken. Depends on rss_pkg, rss_if, rss_ram and rss_mul.

module robot_safety_supervisor
    import rss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rss_in_if.sink        i_in,
    rss_cfg_if.sink       i_cfg,
    rss_out_if.source     o_out
);

    // multiplier steps: the product of step n is consumed at step n+1
    localparam logic [2:0] STEP_SQ_X  = 3'd0;
    localparam logic [2:0] STEP_SQ_Y  = 3'd1;
    localparam logic [2:0] STEP_SQ_Z  = 3'd2;
    localparam logic [2:0] STEP_PITCH = 3'd3;
    localparam logic [2:0] STEP_ROLL  = 3'd4;
    localparam logic [2:0] STEP_TILT  = 3'd5;

    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MOTOR_COUNT);

    t_state                    r_state;
    logic [2:0]                r_step;
    logic [SCAN_W-1:0]         r_scan;
    logic                      r_rd_vld;
    logic [MOTOR_AW-1:0]       r_rd_idx;

    // configuration
    logic [TAN_W-1:0]          r_pitch_tan;
    logic [TAN_W-1:0]          r_roll_tan;
    logic signed [TEMP_W-1:0]  r_temp_limit;
    logic [TOUT_W-1:0]         r_cmd_tout;
    logic [TOUT_W-1:0]         r_imu_tout;

    // retained state
    logic signed [GRAV_W-1:0]  r_gx, r_gy, r_gz;
    logic                      r_grav_seen;
    logic [TS_W-1:0]           r_last_imu;
    logic [TS_W-1:0]           r_last_cmd;
    logic [MOTOR_COUNT-1:0]    r_reported;
    logic                      r_prev_safe;
    logic [KIND_W-1:0]         r_prev_kind;
    logic [MIDX_W-1:0]         r_prev_motor;

    // check working registers
    logic [TS_W-1:0]           r_now;
    logic [ACC_W-1:0]          r_acc;
    logic                      r_pitch_big, r_roll_big;
    logic                      r_t_hit, r_c_hit;
    logic [MOTOR_AW-1:0]       r_t_idx, r_c_idx;
    logic signed [TEMP_W-1:0]  r_t_val;
    logic [CODE_W-1:0]         r_c_val;
    logic                      r_cmd_to, r_imu_to;
    logic [VAL_W-1:0]          r_cmd_e, r_imu_e;

    // result register
    logic                      r_out_valid;
    logic                      r_out_safe;
    logic [KIND_W-1:0]         r_out_kind;
    logic [MIDX_W-1:0]         r_out_motor;
    logic signed [VAL_W-1:0]   r_out_value;
    logic                      r_out_newf;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [MUL_W-1:0]          ext_x, ext_y, mag_x, mag_y;
    logic signed [PROD_W-1:0]  scaled_x, scaled_y;

    logic                      ram_we;
    logic [MOTOR_AW-1:0]       wr_addr;
    logic [MOTOR_WORD_W-1:0]   rd_word;
    logic signed [TEMP_W-1:0]  rd_temp;
    logic [CODE_W-1:0]         rd_code;
    logic                      idx_ok;

    logic [TS_W-1:0]           sub_last, elapsed;
    logic [TOUT_W-1:0]         sub_limit;
    logic [VAL_W-1:0]          elapsed_sat;
    logic                      elapsed_over;

    logic                      tilt_on;
    t_kind                     kind;
    logic [MIDX_W-1:0]         motor;
    logic signed [VAL_W-1:0]   value;
    logic                      safe, newf;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_a = {r_gx[GRAV_W-1], r_gx};
        mul_b = {r_gx[GRAV_W-1], r_gx};
        case (r_step)
            STEP_SQ_Y: begin
                mul_a = {r_gy[GRAV_W-1], r_gy};
                mul_b = {r_gy[GRAV_W-1], r_gy};
            end
            STEP_SQ_Z: begin
                mul_a = {r_gz[GRAV_W-1], r_gz};
                mul_b = {r_gz[GRAV_W-1], r_gz};
            end
            STEP_PITCH: begin
                mul_a = {1'b0, r_pitch_tan};
                mul_b = {r_gz[GRAV_W-1], r_gz};
            end
            STEP_ROLL: begin
                mul_a = {1'b0, r_roll_tan};
                mul_b = {r_gz[GRAV_W-1], r_gz};
            end
            default: ;
        endcase
    end

    rss_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // |a| * 256, compared against tan_limit * z
    assign ext_x    = {r_gx[GRAV_W-1], r_gx};
    assign ext_y    = {r_gy[GRAV_W-1], r_gy};
    assign mag_x    = ext_x[MUL_W-1] ? (~ext_x + MUL_W'(1)) : ext_x;
    assign mag_y    = ext_y[MUL_W-1] ? (~ext_y + MUL_W'(1)) : ext_y;
    assign scaled_x = $signed({(PROD_W-MUL_W-8)'(0), mag_x, 8'b0});
    assign scaled_y = $signed({(PROD_W-MUL_W-8)'(0), mag_y, 8'b0});

    // ---------------- motor table ----------------
    assign idx_ok  = (32'(i_in.motor_index) < MOTOR_COUNT);
    assign wr_addr = MOTOR_AW'(i_in.motor_index);
    assign ram_we  = i_in.valid && i_in.ready && (i_in.operation == OP_MOTOR) && idx_ok;

    rss_ram #(
        .WIDTH (MOTOR_WORD_W),
        .DEPTH (MOTOR_COUNT)
    ) u_motor_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata ({i_in.motor_fault_code, i_in.motor_temperature}),
        .i_raddr (r_scan[MOTOR_AW-1:0]),
        .o_rdata (rd_word)
    );

    assign rd_temp = $signed(rd_word[TEMP_W-1:0]);
    assign rd_code = rd_word[MOTOR_WORD_W-1:TEMP_W];

    // ---------------- shared elapsed-time subtractor ----------------
    assign sub_last     = (r_state == S_CMD) ? r_last_cmd : r_last_imu;
    assign sub_limit    = (r_state == S_CMD) ? r_cmd_tout : r_imu_tout;
    assign elapsed      = r_now - sub_last;
    assign elapsed_over = elapsed > TS_W'(sub_limit);
    assign elapsed_sat  = (elapsed > ELAPSED_MAX) ? VAL_W'(ELAPSED_MAX) : elapsed[VAL_W-1:0];

    // ---------------- fault priority ----------------
    assign tilt_on = r_grav_seen && (r_acc > TILT_MIN_SQ);

    always_comb begin
        kind  = K_NONE;
        motor = '0;
        value = '0;
        // z below zero is past ninety degrees on either axis
        if (tilt_on && (r_gz[GRAV_W-1] || r_pitch_big)) begin
            kind = K_PITCH;
        end else if (tilt_on && (r_gz[GRAV_W-1] || r_roll_big)) begin
            kind = K_ROLL;
        end else if (r_t_hit) begin
            kind  = K_TEMP;
            motor = MIDX_W'(r_t_idx);
            value = VAL_W'(r_t_val);
        end else if (r_c_hit) begin
            kind  = K_MFAULT;
            motor = MIDX_W'(r_c_idx);
            value = $signed({(VAL_W-CODE_W)'(0), r_c_val});
        end else if (r_cmd_to) begin
            kind  = K_CMD_TO;
            value = $signed(r_cmd_e);
        end else if (r_imu_to) begin
            kind  = K_IMU_TO;
            value = $signed(r_imu_e);
        end
    end

    assign safe = (kind == K_NONE);
    assign newf = !safe && (r_prev_safe || (r_prev_kind != kind) || (r_prev_motor != motor));

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= STEP_SQ_X;
            r_scan       <= '0;
            r_rd_vld     <= 1'b0;
            r_pitch_tan  <= PITCH_TAN_RST;
            r_roll_tan   <= ROLL_TAN_RST;
            r_temp_limit <= TEMP_LIM_RST;
            r_cmd_tout   <= CMD_TOUT_RST;
            r_imu_tout   <= IMU_TOUT_RST;
            r_gx         <= '0;
            r_gy         <= '0;
            r_gz         <= GRAV_Z_RST;
            r_grav_seen  <= 1'b0;
            r_last_imu   <= '0;
            r_last_cmd   <= '0;
            r_reported   <= '0;
            r_prev_safe  <= 1'b1;
            r_prev_kind  <= K_NONE;
            r_prev_motor <= '0;
            r_t_hit      <= 1'b0;
            r_c_hit      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_PITCH_TAN: r_pitch_tan  <= i_cfg.data[TAN_W-1:0];
                    CFG_ROLL_TAN:  r_roll_tan   <= i_cfg.data[TAN_W-1:0];
                    CFG_TEMP_LIM:  r_temp_limit <= $signed(i_cfg.data[TEMP_W-1:0]);
                    CFG_CMD_TOUT:  r_cmd_tout   <= i_cfg.data[TOUT_W-1:0];
                    CFG_IMU_TOUT:  r_imu_tout   <= i_cfg.data[TOUT_W-1:0];
                    default: ;
                endcase
            end

            // in S_DONE the result register is refilled instead
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        unique case (i_in.operation)
                            OP_GRAVITY: begin
                                r_gx        <= i_in.gravity_x;
                                r_gy        <= i_in.gravity_y;
                                r_gz        <= i_in.gravity_z;
                                r_grav_seen <= 1'b1;
                            end
                            OP_IMU: r_last_imu <= i_in.timestamp_ms;
                            OP_MOTOR: begin
                                if (idx_ok) begin
                                    r_reported[wr_addr] <= 1'b1;
                                end
                            end
                            OP_COMMAND: r_last_cmd <= i_in.timestamp_ms;
                            OP_CHECK: begin
                                r_now   <= i_in.timestamp_ms;
                                r_step  <= STEP_SQ_X;
                                r_t_hit <= 1'b0;
                                r_c_hit <= 1'b0;
                                r_state <= S_MUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        STEP_SQ_Y:  r_acc       <= ACC_W'(mul_p);
                        STEP_SQ_Z:  r_acc       <= r_acc + ACC_W'(mul_p);
                        STEP_PITCH: r_acc       <= r_acc + ACC_W'(mul_p);
                        STEP_ROLL:  r_pitch_big <= scaled_x > mul_p;
                        STEP_TILT: begin
                            r_roll_big <= scaled_y > mul_p;
                            r_scan     <= '0;
                            r_rd_vld   <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    // read issued in the cycle before its compare
                    r_rd_vld <= (r_scan != SCAN_END);
                    r_rd_idx <= r_scan[MOTOR_AW-1:0];
                    if (r_scan != SCAN_END) begin
                        r_scan <= r_scan + SCAN_W'(1);
                    end else begin
                        r_state <= S_CMD;
                    end
                    if (r_rd_vld && r_reported[r_rd_idx]) begin
                        if (!r_t_hit && (rd_temp > r_temp_limit)) begin
                            r_t_hit <= 1'b1;
                            r_t_idx <= r_rd_idx;
                            r_t_val <= rd_temp;
                        end
                        if (!r_c_hit && (rd_code != '0)) begin
                            r_c_hit <= 1'b1;
                            r_c_idx <= r_rd_idx;
                            r_c_val <= rd_code;
                        end
                    end
                end
                S_CMD: begin
                    r_cmd_to <= elapsed_over;
                    r_cmd_e  <= elapsed_sat;
                    r_state  <= S_IMU;
                end
                S_IMU: begin
                    r_imu_to <= elapsed_over;
                    r_imu_e  <= elapsed_sat;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_safe   <= safe;
                        r_out_kind   <= kind;
                        r_out_motor  <= motor;
                        r_out_value  <= value;
                        r_out_newf   <= newf;
                        r_prev_safe  <= safe;
                        r_prev_kind  <= kind;
                        r_prev_motor <= motor;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.safe        = r_out_safe;
    assign o_out.fault_kind  = r_out_kind;
    assign o_out.fault_motor = r_out_motor;
    assign o_out.fault_value = r_out_value;
    assign o_out.new_fault   = r_out_newf;

    // ---------------- assertions ----------------
    ap_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_END)
        else $error("motor scan counter ran past the table");

    ap_check_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.operation == OP_CHECK)) |=> (r_state == S_MUL))
        else $error("accepted check did not start the multiply sequence");

    ap_newf_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.new_fault) |-> (!o_out.safe && (o_out.fault_kind != K_NONE)))
        else $error("new fault flagged on a safe result");

endmodule
